@@ rtl/cvs_pkg.sv @@
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and codes for the cosine top-k vector search block.
// ----------------------------------------------------------------------------
package cvs_pkg;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_DIM     = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_LONG    = 3'd5;
  localparam logic [2:0] ST_NOMATCH = 3'd6;

  // fraction bits appended to a cosine quotient after the integer bit
  localparam int FRAC_STEPS = 23;

  localparam logic signed [15:0] SCORE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SCORE_MIN = 16'sh8000;

  typedef struct packed {
    logic               command;
    logic signed [31:0] entry_id;
    logic signed [15:0] element;
    logic               last;
    logic [4:0]         top_k;
  } cvs_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] match_id;
    logic signed [15:0] score;
    logic [3:0]         rank;
    logic               last_result;
  } cvs_rsp_t;

endpackage

@@ rtl/cosine_top_k_vector_search.sv @@
// An element that is not last is absorbed while idle (one per cycle).
// After a last element: bit-serial square root, then the decision and response
// states that give the add result. A query scans every stored entry in turn:
// memory reads and accumulation, then serial division and list insertion; it
// then emits one result per cycle while the output is accepted.
// Reset clears the counters, the dimension and the best list; the stores are not cleared.
// ----------------------------------------------------------------------------
// cosine_top_k_vector_search
// Stores vectors with ids and norms; a query ranks stored entries by cosine score.
// ----------------------------------------------------------------------------
module cosine_top_k_vector_search
  import cvs_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_DIM     = 512,
  parameter int MAX_TOP_K   = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  cvs_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output cvs_rsp_t rsp
);

  localparam int TOTAL = MAX_ENTRIES * MAX_DIM;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int EW    = $clog2(MAX_DIM + 2);
  localparam int QW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SCW   = $clog2(MAX_ENTRIES + 1);
  localparam int NW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int KW    = $clog2(MAX_TOP_K + 1);
  localparam int IW    = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
  localparam int SQW   = 31 + $clog2(MAX_DIM + 1);
  localparam int DW    = SQW + 1;
  localparam int RW    = (SQW + 9) / 2;
  localparam int PW    = 2 * RW;
  localparam int MW    = (SQW > PW + 2) ? SQW : PW + 2;
  localparam int QNW   = FRAC_STEPS + 2;
  localparam int CNTW  = $clog2(((RW > FRAC_STEPS) ? RW : FRAC_STEPS) + 1);

  localparam logic [EW-1:0]  DIM_MAX = EW'(MAX_DIM);
  localparam logic [SCW-1:0] ENT_MAX = SCW'(MAX_ENTRIES);
  localparam logic [KW-1:0]  K_MAX   = KW'(MAX_TOP_K);
  localparam logic [AW:0]    STRIDE  = (AW + 1)'(MAX_DIM);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_DECIDE, S_RESP, S_SCAN, S_DRAIN,
    S_PROD, S_DIVI, S_DIV, S_FIN, S_INS, S_EMIT
  } state_t;

  state_t state;

  // memories
  logic signed [15:0] vmem [TOTAL];
  logic signed [15:0] qmem [MAX_DIM];
  logic signed [31:0] idmem [MAX_ENTRIES];
  logic [RW-1:0]      nmem [MAX_ENTRIES];

  // streaming state
  logic [EW-1:0]  ecnt;
  logic [SQW-1:0] sq_sum;
  logic [SCW-1:0] stored;
  logic [EW-1:0]  dim;
  logic [AW:0]    vbase;

  // latched run info
  logic               cmd;
  logic signed [31:0] run_id;
  logic [KW-1:0]      kk;
  logic [EW-1:0]      len;
  logic [2:0]         resp_st;

  // square root unit
  logic [PW-1:0]  sq_x;
  logic [RW+1:0]  sq_r;
  logic [RW-1:0]  root;
  logic [CNTW-1:0] cnt;

  // scan state
  logic [SCW-1:0]     ecur;
  logic [AW:0]        sbase;
  logic [EW-1:0]      si;
  logic [QW-1:0]      rd_i;
  logic [AW-1:0]      rd_a;
  logic               rd_v;
  logic               pv;
  logic signed [15:0] q_rd;
  logic signed [15:0] v_rd;
  logic signed [31:0] id_rd;
  logic [RW-1:0]      nrm_rd;
  logic signed [31:0] prod;
  logic signed [DW-1:0] dot;

  // divider
  logic [PW-1:0]  pden;
  logic [PW:0]    dr;
  logic [QNW-1:0] dq;
  logic           neg;
  logic signed [15:0] sc;

  // best list
  logic signed [15:0] b_sc [MAX_TOP_K];
  logic signed [31:0] b_id [MAX_TOP_K];
  logic [KW-1:0]      fill;
  logic [KW-1:0]      em;

  cvs_rsp_t rsp_r;
  logic     rsp_v;

  logic acc;
  assign acc       = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = rsp_v;
  assign rsp       = rsp_r;

  // element bookkeeping as of this transfer
  logic           in_range;
  logic [SQW-1:0] sum_after;
  logic [EW-1:0]  cnt_after;
  logic signed [31:0] sq_el;
  always_comb begin
    in_range  = (ecnt < DIM_MAX);
    sq_el     = req.element * req.element;
    sum_after = in_range ? sq_sum + SQW'(unsigned'(sq_el)) : sq_sum;
    cnt_after = in_range ? ecnt + EW'(1) : DIM_MAX + EW'(1);
  end

  // square root step
  logic [RW+3:0] sq_sh;
  logic [RW+3:0] sq_t;
  always_comb begin
    sq_sh = {sq_r, sq_x[PW-1 -: 2]};
    sq_t  = {2'b00, root, 2'b01};
  end

  // add decision
  logic [2:0]    add_st;
  logic [EW-1:0] dim_next;
  logic          add_ok;
  always_comb begin
    add_st   = ST_OK;
    dim_next = dim;
    if (len > DIM_MAX) begin
      add_st = ST_LONG;
    end else if (dim == '0) begin
      dim_next = len;
    end else if (len != dim) begin
      add_st = ST_DIM;
    end
    if (add_st == ST_OK && root == '0) add_st = ST_ZERO;
    if (add_st == ST_OK && stored >= ENT_MAX) add_st = ST_FULL;
    add_ok = (add_st == ST_OK);
  end

  // query decision
  logic [2:0] qry_st;
  always_comb begin
    qry_st = ST_OK;
    if (kk == '0 || stored == '0) qry_st = ST_NOMATCH;
    else if (len > DIM_MAX)       qry_st = ST_LONG;
    else if (len != dim)          qry_st = ST_DIM;
    else if (root == '0)          qry_st = ST_ZERO;
  end

  // divider compare values
  logic [DW-1:0] mag_w;
  logic [MW-1:0] mag;
  logic [MW-1:0] p_m;
  logic [PW+1:0] dr_sh;
  always_comb begin
    mag_w = dot[DW-1] ? -dot : dot;
    mag   = MW'(mag_w[SQW-1:0]);
    p_m   = MW'(pden);
    dr_sh = {dr, 1'b0};
  end

  // insertion into the sorted list
  logic [MAX_TOP_K-1:0] ge;
  logic [MAX_TOP_K-1:0] ge_prev;
  logic                 ins_ok;
  always_comb begin
    ins_ok = 1'b0;
    for (int j = 0; j < MAX_TOP_K; j++) begin
      ge[j] = (KW'(j) < fill) && (b_sc[j] >= sc);
    end
    for (int j = 0; j < MAX_TOP_K; j++) begin
      ge_prev[j] = (j == 0) ? 1'b1 : ge[(j == 0) ? 0 : j - 1];
      if (KW'(j) < kk && !ge[j]) ins_ok = 1'b1;
    end
  end

  // memories: element writes, add writes, registered reads
  always_ff @(posedge clk) begin
    if (acc && in_range) begin
      qmem[ecnt[QW-1:0]] <= req.element;
      if (stored < ENT_MAX) vmem[AW'(vbase + (AW + 1)'(ecnt))] <= req.element;
    end
    if (state == S_DECIDE && cmd == CMD_ADD && add_ok) begin
      idmem[stored[NW-1:0]] <= run_id;
      nmem[stored[NW-1:0]]  <= root;
    end
    q_rd   <= qmem[rd_i];
    v_rd   <= vmem[rd_a];
    id_rd  <= idmem[ecur[NW-1:0]];
    nrm_rd <= nmem[ecur[NW-1:0]];
  end

  // read addresses of the scan
  always_comb begin
    rd_i = si[QW-1:0];
    rd_a = AW'(sbase + (AW + 1)'(si));
  end

  // best list storage
  always_ff @(posedge clk) begin
    if (state == S_INS && ins_ok) begin
      for (int j = 0; j < MAX_TOP_K; j++) begin
        if (KW'(j) < kk && !ge[j]) begin
          if (ge_prev[j]) begin
            b_sc[j] <= sc;
            b_id[j] <= id_rd;
          end else begin
            b_sc[j] <= b_sc[(j == 0) ? 0 : j - 1];
            b_id[j] <= b_id[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ecnt   <= '0;
      sq_sum <= '0;
      stored <= '0;
      dim    <= '0;
      vbase  <= '0;
      fill   <= '0;
      rd_v   <= 1'b0;
      pv     <= 1'b0;
      rsp_v  <= 1'b0;
    end else begin
      if (rsp_v && rsp_ready) rsp_v <= 1'b0;
      // multiply and accumulate pipeline
      rd_v <= 1'b0;
      pv   <= rd_v;
      if (rd_v) prod <= q_rd * v_rd;
      if (pv) dot <= dot + DW'(prod);

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (req.last) begin
              cmd    <= req.command;
              run_id <= req.entry_id;
              kk     <= (32'(req.top_k) > MAX_TOP_K) ? K_MAX : KW'(req.top_k);
              len    <= cnt_after;
              sq_x   <= PW'(sum_after) << 8;
              sq_r   <= '0;
              root   <= '0;
              cnt    <= '0;
              ecnt   <= '0;
              sq_sum <= '0;
              state  <= S_SQRT;
            end else begin
              ecnt   <= cnt_after;
              sq_sum <= sum_after;
            end
          end
        end
        S_SQRT: begin
          sq_x <= sq_x << 2;
          if (sq_sh >= sq_t) begin
            sq_r <= (RW + 2)'(sq_sh - sq_t);
            root <= {root[RW-2:0], 1'b1};
          end else begin
            sq_r <= (RW + 2)'(sq_sh);
            root <= {root[RW-2:0], 1'b0};
          end
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(RW - 1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (cmd == CMD_ADD) begin
            dim <= dim_next;
            if (add_ok) begin
              stored <= stored + SCW'(1);
              vbase  <= vbase + STRIDE;
            end
            resp_st <= add_st;
            state   <= S_RESP;
          end else if (qry_st != ST_OK) begin
            resp_st <= qry_st;
            state   <= S_RESP;
          end else begin
            fill  <= '0;
            ecur  <= '0;
            sbase <= '0;
            si    <= '0;
            dot   <= '0;
            state <= S_SCAN;
          end
        end
        // single status result once the output register is free
        S_RESP: begin
          if (!rsp_v || rsp_ready) begin
            rsp_v <= 1'b1;
            rsp_r <= '{status: resp_st, match_id: '0, score: '0, rank: '0,
                       last_result: 1'b1};
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          rd_v <= 1'b1;
          si   <= si + EW'(1);
          if (si == len - EW'(1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_v && !pv) state <= S_PROD;
        end
        S_PROD: begin
          pden  <= PW'(root) * PW'(nrm_rd);
          neg   <= dot[DW-1];
          state <= S_DIVI;
        end
        S_DIVI: begin
          cnt <= '0;
          if (pden == '0) begin
            sc    <= '0;
            state <= S_INS;
          end else if (mag >= (p_m << 1)) begin
            sc    <= neg ? SCORE_MIN : SCORE_MAX;
            state <= S_INS;
          end else if (mag >= p_m) begin
            dr    <= (PW + 1)'(mag - p_m);
            dq    <= QNW'(1);
            state <= S_DIV;
          end else begin
            dr    <= (PW + 1)'(mag);
            dq    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dr_sh >= (PW + 2)'(pden)) begin
            dr <= (PW + 1)'(dr_sh - (PW + 2)'(pden));
            dq <= {dq[QNW-2:0], 1'b1};
          end else begin
            dr <= (PW + 1)'(dr_sh);
            dq <= {dq[QNW-2:0], 1'b0};
          end
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(FRAC_STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (neg) sc <= (dq > QNW'(32768)) ? SCORE_MIN : -16'(dq);
          else     sc <= (dq > QNW'(32767)) ? SCORE_MAX : 16'(dq);
          state <= S_INS;
        end
        S_INS: begin
          if (ins_ok && fill < kk) fill <= fill + KW'(1);
          if (ecur + SCW'(1) < stored) begin
            ecur  <= ecur + SCW'(1);
            sbase <= sbase + STRIDE;
            si    <= '0;
            dot   <= '0;
            state <= S_SCAN;
          end else begin
            em    <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp_v || rsp_ready) begin
            rsp_v <= 1'b1;
            rsp_r <= '{status: ST_OK, match_id: b_id[em[IW-1:0]], score: b_sc[em[IW-1:0]],
                       rank: 4'(em), last_result: (em + KW'(1) == fill)};
            em    <= em + KW'(1);
            if (em + KW'(1) == fill) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
